// ----- hw/rtl/pib_pkg.sv -----
// Package for the palette index builder: request and result structs,
// the token that walks the cell chain, and fixed field widths.
// No dependencies.
package pib_pkg;

  localparam int IDX_W = 8;  // palette index width
  localparam int CNT_W = 9;  // color count width (holds the depth itself)
  localparam int COLOR_W = 32;

  // One pixel request
  typedef struct packed {
    logic       start_of_image;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pib_in_t;

  // One result
  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             new_color;
    logic             overflow;
    logic [CNT_W-1:0] color_count;
  } pib_out_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               done;   // matched or appended somewhere upstream
    logic               added;  // done by appending a new entry
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pib_tok_t;

endpackage

// ----- hw/rtl/pib_cell.sv -----
// One palette cell: holds one color entry and passes the search token on.
// Depends on pib_pkg.
module pib_cell
  import pib_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cnt_i,   // number of stored colors
  input  pib_tok_t         tok_i,
  output pib_tok_t         tok_o
);

  localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(CELL_IDX);

  logic [COLOR_W-1:0] entry_r, entry_nxt;
  pib_tok_t           tok_r, tok_nxt;

  // Compare against a live entry, or claim this cell when it is the tail
  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (POS_CNT < cnt_i) begin
        if (entry_r == tok_i.color) begin
          tok_nxt.done = 1'b1;
          tok_nxt.idx  = POS_IDX;
        end
      end else if (POS_CNT == cnt_i) begin
        entry_nxt     = tok_i.color;
        tok_nxt.done  = 1'b1;
        tok_nxt.added = 1'b1;
        tok_nxt.idx   = POS_IDX;
      end
    end
  end

  // Entry needs no reset: only cells below the count are compared
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- hw/rtl/pib_out_buf.sv -----
// Two-deep result buffer: output register plus skid entry, so a finished
// result can wait while the next request is already in the chain.
// Depends on pib_pkg.
module pib_out_buf
  import pib_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_vld,
  input  pib_out_t res,
  output logic     skid_full,
  output logic     out_valid,
  input  logic     out_stall,
  output pib_out_t out_data
);

  logic     out_vld_r, out_vld_nxt;
  pib_out_t out_r, out_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  pib_out_t skid_r, skid_nxt;
  logic     take;

  assign take = out_vld_r && !out_stall;

  // Refill the output register from the skid first, keeping order
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = res_vld;
        skid_nxt     = res;
      end else begin
        out_vld_nxt = res_vld;
        out_nxt     = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign skid_full = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/palette_index_builder_top.sv -----
// Palette index builder top: a chain of PALETTE_DEPTH cells searched by a token.
// Only one pixel is in the chain at a time: the token walks every cell of the chain,
// one cell a cycle, and the next request waits until the token has left the chain.
// Reset (rst_n low, synchronous) empties the palette and the result buffer.
// Depends on pib_pkg, pib_cell, pib_out_buf.
module palette_index_builder_top
  import pib_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pib_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pib_out_t out_data
);

  pib_tok_t         tok [PALETTE_DEPTH+1];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cnt_bcast;
  logic             busy_r, busy_nxt;
  logic             in_acc;
  logic             skid_full;
  logic             end_vld;
  pib_out_t         res;

  assign in_stall = busy_r || skid_full;
  assign in_acc   = in_valid && !in_stall;

  // Launch the token into the first cell
  always_comb begin
    tok[0].vld   = in_acc;
    tok[0].done  = 1'b0;
    tok[0].added = 1'b0;
    tok[0].idx   = '0;
    tok[0].color = {in_data.red, in_data.green, in_data.blue, in_data.alpha};
  end

  // Start of image empties the palette before the first cell looks at it
  assign cnt_bcast = (in_acc && in_data.start_of_image) ? '0 : count_r;

  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    pib_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cnt_i (cnt_bcast),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // Token leaving the chain: not done means the palette was full
  assign end_vld = tok[PALETTE_DEPTH].vld;

  always_comb begin
    res.new_color   = tok[PALETTE_DEPTH].added;
    res.overflow    = !tok[PALETTE_DEPTH].done;
    res.color_index = tok[PALETTE_DEPTH].done ? tok[PALETTE_DEPTH].idx : '0;
    res.color_count = count_r + CNT_W'(tok[PALETTE_DEPTH].added);
  end

  // Color count and busy flag
  always_comb begin
    count_nxt = count_r;
    busy_nxt  = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      if (in_data.start_of_image) begin
        count_nxt = '0;
      end
    end else if (end_vld) begin
      busy_nxt  = 1'b0;
      count_nxt = res.color_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
    end
  end

  pib_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (end_vld),
    .res       (res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/pib_checker.sv -----
// Port-level checks for the palette index builder, bound to the top level.
// Depends on pib_pkg and palette_index_builder_top.
module pib_checker
  import pib_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pib_out_t out_data
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // One pixel in the chain at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while chain busy");

  // Overflow means a full palette and index zero, never a new entry
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      !out_data.new_color && out_data.color_index == '0 &&
      out_data.color_count == DEPTH_CNT)
    else $error("bad overflow result");

  // A new entry is the last one in the palette
  a_new_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_color |->
      CNT_W'(out_data.color_index) + CNT_W'(1) == out_data.color_count)
    else $error("new color index does not match count");

  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.color_count <= DEPTH_CNT)
    else $error("color count beyond palette depth");

endmodule

bind palette_index_builder_top pib_checker #(
  .PALETTE_DEPTH(PALETTE_DEPTH)
) u_pib_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
